// ===== design/look_disk_scheduler_defines.svh =====
// Assertion macros shared by the LOOK/C-LOOK scheduler RTL.
`ifndef LOOK_DISK_SCHEDULER_DEFINES_SVH
`define LOOK_DISK_SCHEDULER_DEFINES_SVH

`ifndef SYNTH

`define LDS_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lds assertion failed");

`define LDS_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lds assertion failed");

`else

`define LDS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define LDS_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== design/lds_pkg.sv =====
// Constants and codes of the LOOK/C-LOOK disk scheduler.
package lds_pkg;

  localparam int MAX_REQUESTS = 64;
  localparam int TRACK_W      = 16;
  localparam int TOTAL_W      = 22;
  localparam int IDX_W        = $clog2(MAX_REQUESTS);
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int REG_IDX_W    = 2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_HEAD_START      = 2'd0,
    REG_START_DIRECTION = 2'd1,
    REG_SWEEP_MODE      = 2'd2
  } reg_idx_e;

endpackage

// ===== design/look_disk_scheduler.sv =====
// LOOK / C-LOOK disk head scheduler: request store, ordering scans and result register.
//
// Usage:
//   Request channel (in_valid_i / in_stall_o, func_i, track_i): func_i = 0 loads
//   track_i into the request store; loads beyond the store capacity
//   are dropped and flagged. func_i = 1 starts a run.
//   Result channel (out_valid_o / out_stall_i): a run returns one result per
//   served request in service order, last_o high on the final one; a run with
//   nothing to serve returns a single result with empty_run_o high.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (head start, start direction, sweep mode). The user must write only while
//   the block is idle; the block itself does not enforce this.
// Operation:
//   A run first counts the stored requests, then finds each next request
//   with a full scan of the store through its single read port, plus one
//   extra scan when the sweep turns. The request side stalls for the whole
//   run.
// Reset clears request count, overflow flag, head start and sweep mode; dir set to 1.
// A stalled result holds in the output register; the next scan still runs, then waits.
`include "look_disk_scheduler_defines.svh"

module look_disk_scheduler
  import lds_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [TRACK_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [TRACK_W-1:0]   track_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [TRACK_W-1:0]   served_track_o,
  output logic [TRACK_W-1:0]   move_distance_o,
  output logic [TOTAL_W-1:0]   total_movement_o,
  output logic [CNT_W-1:0]     served_count_o,
  output logic                 empty_run_o,
  output logic                 overflow_seen_o,
  output logic                 last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e state_q;

  logic [TRACK_W-1:0] head_start_q;
  logic               dir_q;
  logic               mode_q;

  logic [TRACK_W-1:0] mem [MAX_REQUESTS];
  logic [TRACK_W-1:0] rdata_q;

  logic [CNT_W-1:0]        req_cnt_q;
  logic                    ovf_q;
  logic [MAX_REQUESTS-1:0] served_q;
  logic [CNT_W-1:0]        ptr_q;
  logic                    rd_vld_q;
  logic [IDX_W-1:0]        rd_idx_q;
  logic [CNT_W-1:0]        n_q;
  logic                    phase_q;
  logic                    found_q;
  logic [TRACK_W-1:0]      best_q;
  logic [IDX_W-1:0]        best_idx_q;
  logic [TRACK_W-1:0]      pos_q;
  logic [TOTAL_W-1:0]      run_total_q;
  logic [CNT_W-1:0]        run_cnt_q;
  logic                    empty_q;

  logic                    in_fire;
  logic                    issue;
  logic                    scan_done;
  logic                    side_high;
  logic                    pick_min;
  logic                    on_side;
  logic                    better;
  logic                    take;
  logic                    emit_fire;
  logic                    emit_last;
  logic [TRACK_W-1:0]      travel;
  logic [TOTAL_W-1:0]      total_sum;
  logic [CNT_W-1:0]        cnt_inc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  assign issue     = ((state_q == ST_COUNT) || (state_q == ST_SCAN)) && (ptr_q < req_cnt_q);
  assign scan_done = (ptr_q == req_cnt_q) && !rd_vld_q;

  assign side_high = phase_q ? !dir_q : dir_q;
  assign pick_min  = phase_q ? (mode_q ? dir_q : !dir_q) : dir_q;
  assign on_side   = side_high ? (rdata_q > head_start_q) : (rdata_q < head_start_q);
  assign better    = !found_q || (pick_min ? (rdata_q < best_q) : (rdata_q > best_q));
  assign take      = rd_vld_q && !served_q[rd_idx_q] && on_side && better;

  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_o || !out_stall_i);
  assign travel    = (best_q > pos_q) ? (best_q - pos_q) : (pos_q - best_q);
  assign total_sum = run_total_q + TOTAL_W'(travel);
  assign cnt_inc   = run_cnt_q + CNT_W'(1);
  assign emit_last = empty_q || (cnt_inc == n_q);

  always_ff @(posedge clk_i) begin
    if (in_fire && (func_i == FUNC_LOAD) && (req_cnt_q < CNT_W'(MAX_REQUESTS))) begin
      mem[req_cnt_q[IDX_W-1:0]] <= track_i;
    end
    rdata_q <= mem[ptr_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_start_q <= '0;
      dir_q        <= 1'b1;
      mode_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HEAD_START:      head_start_q <= cfg_data_i;
        REG_START_DIRECTION: dir_q        <= cfg_data_i[0];
        REG_SWEEP_MODE:      mode_q       <= cfg_data_i[0];
        default:             ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      req_cnt_q        <= '0;
      ovf_q            <= 1'b0;
      served_q         <= '0;
      ptr_q            <= '0;
      rd_vld_q         <= 1'b0;
      rd_idx_q         <= '0;
      n_q              <= '0;
      phase_q          <= 1'b0;
      found_q          <= 1'b0;
      best_q           <= '0;
      best_idx_q       <= '0;
      pos_q            <= '0;
      run_total_q      <= '0;
      run_cnt_q        <= '0;
      empty_q          <= 1'b0;
      out_valid_o      <= 1'b0;
      served_track_o   <= '0;
      move_distance_o  <= '0;
      total_movement_o <= '0;
      served_count_o   <= '0;
      empty_run_o      <= 1'b0;
      overflow_seen_o  <= 1'b0;
      last_o           <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      rd_idx_q <= ptr_q[IDX_W-1:0];
      if (issue) begin
        ptr_q <= ptr_q + CNT_W'(1);
      end
      if (!out_stall_i && !emit_fire) begin
        out_valid_o <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (func_i == FUNC_LOAD) begin
              if (req_cnt_q < CNT_W'(MAX_REQUESTS)) begin
                req_cnt_q <= req_cnt_q + CNT_W'(1);
              end else begin
                ovf_q <= 1'b1;
              end
            end else begin
              state_q     <= ST_COUNT;
              ptr_q       <= '0;
              n_q         <= '0;
              phase_q     <= 1'b0;
              found_q     <= 1'b0;
              served_q    <= '0;
              pos_q       <= head_start_q;
              run_total_q <= '0;
              run_cnt_q   <= '0;
              empty_q     <= 1'b0;
            end
          end
        end

        ST_COUNT: begin
          if (rd_vld_q && (rdata_q != head_start_q)) begin
            n_q <= n_q + CNT_W'(1);
          end
          if (scan_done) begin
            ptr_q <= '0;
            if (n_q == '0) begin
              empty_q <= 1'b1;
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          if (take) begin
            found_q    <= 1'b1;
            best_q     <= rdata_q;
            best_idx_q <= rd_idx_q;
          end
          if (scan_done) begin
            ptr_q <= '0;
            if (found_q) begin
              state_q <= ST_EMIT;
            end else begin
              phase_q <= 1'b1;
            end
          end
        end

        ST_EMIT: begin
          if (emit_fire) begin
            out_valid_o     <= 1'b1;
            overflow_seen_o <= ovf_q;
            last_o          <= emit_last;
            empty_run_o     <= empty_q;
            if (empty_q) begin
              served_track_o   <= '0;
              move_distance_o  <= '0;
              total_movement_o <= '0;
              served_count_o   <= '0;
            end else begin
              served_track_o       <= best_q;
              move_distance_o      <= travel;
              total_movement_o     <= total_sum;
              served_count_o       <= cnt_inc;
              run_total_q          <= total_sum;
              run_cnt_q            <= cnt_inc;
              pos_q                <= best_q;
              served_q[best_idx_q] <= 1'b1;
            end
            found_q <= 1'b0;
            ptr_q   <= '0;
            if (emit_last) begin
              req_cnt_q <= '0;
              ovf_q     <= 1'b0;
              state_q   <= ST_IDLE;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `LDS_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, req_cnt_q <= CNT_W'(MAX_REQUESTS))
  `LDS_ASSERT_IMP(a_emit_has_pick, clk_i, rst_ni, (state_q == ST_EMIT) && !empty_q, found_q)
  `LDS_ASSERT_NXT(a_last_clears, clk_i, rst_ni, emit_fire && emit_last,
                  (req_cnt_q == '0) && !ovf_q && (state_q == ST_IDLE))
  `LDS_ASSERT_IMP(a_load_idle, clk_i, rst_ni, in_fire, state_q == ST_IDLE)

endmodule
